[rtl/rmbb_pkg.sv]
`default_nettype none

package rmbb_pkg;

  // Field widths.
  localparam int unsigned CoordW  = 14;
  localparam int unsigned AreaW   = 25;
  localparam int unsigned Sum1W   = 36;
  localparam int unsigned Sum2W   = 48;
  localparam int unsigned FuncW   = 2;

  // Default largest pixel coordinate.
  localparam int unsigned MAX_COORD_DEF = 4095;

  // Empty box minimum and the count limit.
  localparam logic [CoordW-1:0] BOX_EMPTY  = 14'd10000;
  localparam logic [AreaW-1:0]  AREA_LIMIT = 25'd16777216;

  localparam logic [63:0] MASK36 = 64'h0000_000F_FFFF_FFFF;
  localparam logic [63:0] MASK48 = 64'h0000_FFFF_FFFF_FFFF;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_MERGE = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // Operands of one word after clamping and forming the coordinate products, ready to accumulate.
  typedef struct packed {
    func_t             op;
    logic [AreaW-1:0]  d_area;
    logic [Sum1W-1:0]  d_x;
    logic [Sum1W-1:0]  d_y;
    logic [Sum2W-1:0]  d_xx;
    logic [Sum2W-1:0]  d_xy;
    logic [Sum2W-1:0]  d_yy;
    logic [CoordW-1:0] mn_x;
    logic [CoordW-1:0] mn_y;
    logic [CoordW-1:0] mx_x;
    logic [CoordW-1:0] mx_y;
  } addend_t;

  // Saturation limit of the first-order sums.
  function automatic logic [63:0] lim1(input int unsigned mc);
    logic [63:0] p;
    p = 64'(AREA_LIMIT) * 64'(mc);
    return (p > MASK36) ? MASK36 : p;
  endfunction

  // Saturation limit of the second-order sums.
  function automatic logic [63:0] lim2(input int unsigned mc);
    logic [63:0] p;
    p = 64'(AREA_LIMIT) * 64'(mc) * 64'(mc);
    return (p > MASK48) ? MASK48 : p;
  endfunction

endpackage

`default_nettype wire

[rtl/region_moment_bbox_accumulator.sv]
`default_nettype none

// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+-----------
// input    | in_valid, in_stall, in_<field> (11)     | word in
// result   | out_valid, out_stall, out_<field> (10)  | word out
//
// One word is accepted per cycle while the input does not stall. A word's
// result appears once it has passed the operand register (clamp and
// products), which loads at the accepting edge, and the accumulate stage,
// whose state registers are the result register. The saturating add and
// compare on the region state sets the rate. Reset leaves an empty region
// and no words in flight. A stalled result holds, and the input stalls
// only when the operand register is full and cannot move on.
module region_moment_bbox_accumulator #(
  parameter int unsigned MAX_COORD = rmbb_pkg::MAX_COORD_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rmbb_pkg::FuncW-1:0]    in_func,
  input  wire logic [rmbb_pkg::CoordW-1:0]   in_x_or_min_x,
  input  wire logic [rmbb_pkg::CoordW-1:0]   in_y_or_min_y,
  input  wire logic [rmbb_pkg::CoordW-1:0]   in_child_max_x,
  input  wire logic [rmbb_pkg::CoordW-1:0]   in_child_max_y,
  input  wire logic [rmbb_pkg::AreaW-1:0]    in_child_area,
  input  wire logic [rmbb_pkg::Sum1W-1:0]    in_child_sum_x,
  input  wire logic [rmbb_pkg::Sum1W-1:0]    in_child_sum_y,
  input  wire logic [rmbb_pkg::Sum2W-1:0]    in_child_sum_xx,
  input  wire logic [rmbb_pkg::Sum2W-1:0]    in_child_sum_xy,
  input  wire logic [rmbb_pkg::Sum2W-1:0]    in_child_sum_yy,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rmbb_pkg::AreaW-1:0]         out_area,
  output logic [rmbb_pkg::Sum1W-1:0]         out_sum_x,
  output logic [rmbb_pkg::Sum1W-1:0]         out_sum_y,
  output logic [rmbb_pkg::Sum2W-1:0]         out_sum_xx,
  output logic [rmbb_pkg::Sum2W-1:0]         out_sum_xy,
  output logic [rmbb_pkg::Sum2W-1:0]         out_sum_yy,
  output logic [rmbb_pkg::CoordW-1:0]        out_min_x,
  output logic [rmbb_pkg::CoordW-1:0]        out_min_y,
  output logic [rmbb_pkg::CoordW-1:0]        out_max_x,
  output logic [rmbb_pkg::CoordW-1:0]        out_max_y
);

  localparam logic [rmbb_pkg::Sum1W-1:0] Lim1 =
    rmbb_pkg::Sum1W'(rmbb_pkg::lim1(MAX_COORD));
  localparam logic [rmbb_pkg::Sum2W-1:0] Lim2 =
    rmbb_pkg::Sum2W'(rmbb_pkg::lim2(MAX_COORD));

  // Operand register.
  rmbb_pkg::addend_t prep_addend;
  rmbb_pkg::addend_t a_r, a_nxt;
  logic              a_valid_r, a_valid_nxt;

  // Region state; it doubles as the result register.
  logic [rmbb_pkg::AreaW-1:0]  area_r, area_nxt;
  logic [rmbb_pkg::Sum1W-1:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic [rmbb_pkg::Sum2W-1:0]  sxx_r, sxx_nxt, sxy_r, sxy_nxt, syy_r, syy_nxt;
  logic [rmbb_pkg::CoordW-1:0] mnx_r, mnx_nxt, mny_r, mny_nxt;
  logic [rmbb_pkg::CoordW-1:0] mxx_r, mxx_nxt, mxy_r, mxy_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        advance;
  logic [rmbb_pkg::AreaW:0]    s_area;
  logic [rmbb_pkg::Sum1W:0]    s_x, s_y;
  logic [rmbb_pkg::Sum2W:0]    s_xx, s_xy, s_yy;

  rmbb_prep #(
    .MAX_COORD (MAX_COORD)
  ) u_prep (
    .func         (in_func),
    .x_or_min_x   (in_x_or_min_x),
    .y_or_min_y   (in_y_or_min_y),
    .child_max_x  (in_child_max_x),
    .child_max_y  (in_child_max_y),
    .child_area   (in_child_area),
    .child_sum_x  (in_child_sum_x),
    .child_sum_y  (in_child_sum_y),
    .child_sum_xx (in_child_sum_xx),
    .child_sum_xy (in_child_sum_xy),
    .child_sum_yy (in_child_sum_yy),
    .addend       (prep_addend)
  );

  // The operand word moves into the state when the result register is free
  // or is being emptied in this cycle.
  assign advance  = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = a_valid_r && !advance;

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_nxt       = a_r;
    if (!in_stall) begin
      a_valid_nxt = in_valid;
      if (in_valid) begin
        a_nxt = prep_addend;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // The state never exceeds its limit and the operands are capped at it,
  // so one extra bit holds the raw sum and a single compare saturates it.
  assign s_area = {1'b0, area_r} + {1'b0, a_r.d_area};
  assign s_x    = {1'b0, sx_r} + {1'b0, a_r.d_x};
  assign s_y    = {1'b0, sy_r} + {1'b0, a_r.d_y};
  assign s_xx   = {1'b0, sxx_r} + {1'b0, a_r.d_xx};
  assign s_xy   = {1'b0, sxy_r} + {1'b0, a_r.d_xy};
  assign s_yy   = {1'b0, syy_r} + {1'b0, a_r.d_yy};

  always_comb begin
    area_nxt = area_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    sxx_nxt  = sxx_r;
    sxy_nxt  = sxy_r;
    syy_nxt  = syy_r;
    mnx_nxt  = mnx_r;
    mny_nxt  = mny_r;
    mxx_nxt  = mxx_r;
    mxy_nxt  = mxy_r;
    if (advance) begin
      case (a_r.op) inside
        rmbb_pkg::FUNC_ADD, rmbb_pkg::FUNC_MERGE: begin
          area_nxt = (s_area > {1'b0, rmbb_pkg::AREA_LIMIT}) ?
                     rmbb_pkg::AREA_LIMIT : s_area[rmbb_pkg::AreaW-1:0];
          sx_nxt   = (s_x > {1'b0, Lim1}) ? Lim1 : s_x[rmbb_pkg::Sum1W-1:0];
          sy_nxt   = (s_y > {1'b0, Lim1}) ? Lim1 : s_y[rmbb_pkg::Sum1W-1:0];
          sxx_nxt  = (s_xx > {1'b0, Lim2}) ? Lim2 : s_xx[rmbb_pkg::Sum2W-1:0];
          sxy_nxt  = (s_xy > {1'b0, Lim2}) ? Lim2 : s_xy[rmbb_pkg::Sum2W-1:0];
          syy_nxt  = (s_yy > {1'b0, Lim2}) ? Lim2 : s_yy[rmbb_pkg::Sum2W-1:0];
          mnx_nxt  = (a_r.mn_x < mnx_r) ? a_r.mn_x : mnx_r;
          mny_nxt  = (a_r.mn_y < mny_r) ? a_r.mn_y : mny_r;
          mxx_nxt  = (a_r.mx_x > mxx_r) ? a_r.mx_x : mxx_r;
          mxy_nxt  = (a_r.mx_y > mxy_r) ? a_r.mx_y : mxy_r;
        end
        rmbb_pkg::FUNC_CLEAR: begin
          area_nxt = '0;
          sx_nxt   = '0;
          sy_nxt   = '0;
          sxx_nxt  = '0;
          sxy_nxt  = '0;
          syy_nxt  = '0;
          mnx_nxt  = rmbb_pkg::BOX_EMPTY;
          mny_nxt  = rmbb_pkg::BOX_EMPTY;
          mxx_nxt  = '0;
          mxy_nxt  = '0;
        end
        default: begin
          // The unused selector leaves the region as it is and still
          // returns its statistics.
        end
      endcase
    end
  end

  // Operand payload needs no reset; only its valid flag does.
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      area_r      <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      sxy_r       <= '0;
      syy_r       <= '0;
      mnx_r       <= rmbb_pkg::BOX_EMPTY;
      mny_r       <= rmbb_pkg::BOX_EMPTY;
      mxx_r       <= '0;
      mxy_r       <= '0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      area_r      <= area_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      sxx_r       <= sxx_nxt;
      sxy_r       <= sxy_nxt;
      syy_r       <= syy_nxt;
      mnx_r       <= mnx_nxt;
      mny_r       <= mny_nxt;
      mxx_r       <= mxx_nxt;
      mxy_r       <= mxy_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_area   = area_r;
  assign out_sum_x  = sx_r;
  assign out_sum_y  = sy_r;
  assign out_sum_xx = sxx_r;
  assign out_sum_xy = sxy_r;
  assign out_sum_yy = syy_r;
  assign out_min_x  = mnx_r;
  assign out_min_y  = mny_r;
  assign out_max_x  = mxx_r;
  assign out_max_y  = mxy_r;

  // A full operand register facing a stalled result must hold the input.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && out_valid_r && out_stall) |-> (in_stall && !advance))
    else $error("operand word not held while the result is stalled");

  // A clear that reaches the state leaves an empty region.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && a_r.op == rmbb_pkg::FUNC_CLEAR) |=>
      (out_area == '0 && out_sum_x == '0 && out_sum_xx == '0 &&
       out_min_x == rmbb_pkg::BOX_EMPTY && out_max_y == '0))
    else $error("clear did not restore the empty region");

  // Sums never shrink except on a clear.
  a_sums_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && a_r.op != rmbb_pkg::FUNC_CLEAR) |=>
      (out_sum_x >= $past(out_sum_x) && out_sum_yy >= $past(out_sum_yy) &&
       out_area >= $past(out_area)))
    else $error("a region sum decreased without a clear");

  // The state does not change while its result waits.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_area) && $stable(out_sum_xy) &&
                                  $stable(out_min_y) && $stable(out_max_x)))
    else $error("region state changed under a stalled result");

endmodule

`default_nettype wire

[rtl/rmbb_prep.sv]
`default_nettype none

// Clamps the coordinates and child values of one word and forms the
// coordinate products, so that the accumulate stage only adds and compares.
module rmbb_prep #(
  parameter int unsigned MAX_COORD = rmbb_pkg::MAX_COORD_DEF
) (
  input  wire logic [rmbb_pkg::FuncW-1:0]  func,
  input  wire logic [rmbb_pkg::CoordW-1:0] x_or_min_x,
  input  wire logic [rmbb_pkg::CoordW-1:0] y_or_min_y,
  input  wire logic [rmbb_pkg::CoordW-1:0] child_max_x,
  input  wire logic [rmbb_pkg::CoordW-1:0] child_max_y,
  input  wire logic [rmbb_pkg::AreaW-1:0]  child_area,
  input  wire logic [rmbb_pkg::Sum1W-1:0]  child_sum_x,
  input  wire logic [rmbb_pkg::Sum1W-1:0]  child_sum_y,
  input  wire logic [rmbb_pkg::Sum2W-1:0]  child_sum_xx,
  input  wire logic [rmbb_pkg::Sum2W-1:0]  child_sum_xy,
  input  wire logic [rmbb_pkg::Sum2W-1:0]  child_sum_yy,
  output rmbb_pkg::addend_t                addend
);

  localparam logic [rmbb_pkg::CoordW-1:0] MaxC = rmbb_pkg::CoordW'(MAX_COORD);
  localparam logic [rmbb_pkg::Sum1W-1:0] Lim1 =
    rmbb_pkg::Sum1W'(rmbb_pkg::lim1(MAX_COORD));
  localparam logic [rmbb_pkg::Sum2W-1:0] Lim2 =
    rmbb_pkg::Sum2W'(rmbb_pkg::lim2(MAX_COORD));
  localparam int unsigned ProdW = 2 * rmbb_pkg::CoordW;

  logic [rmbb_pkg::CoordW-1:0] px, py;
  logic [ProdW-1:0]            pxx, pxy, pyy;

  function automatic logic [rmbb_pkg::CoordW-1:0] box_clamp(
    input logic [rmbb_pkg::CoordW-1:0] v
  );
    return (v > rmbb_pkg::BOX_EMPTY) ? rmbb_pkg::BOX_EMPTY : v;
  endfunction

  assign px  = (x_or_min_x > MaxC) ? MaxC : x_or_min_x;
  assign py  = (y_or_min_y > MaxC) ? MaxC : y_or_min_y;
  assign pxx = px * px;
  assign pxy = px * py;
  assign pyy = py * py;

  always_comb begin
    addend    = '0;
    addend.op = rmbb_pkg::func_t'(func);
    case (func)
      rmbb_pkg::FUNC_ADD: begin
        addend.d_area = rmbb_pkg::AreaW'(1);
        addend.d_x    = rmbb_pkg::Sum1W'(px);
        addend.d_y    = rmbb_pkg::Sum1W'(py);
        addend.d_xx   = rmbb_pkg::Sum2W'(pxx);
        addend.d_xy   = rmbb_pkg::Sum2W'(pxy);
        addend.d_yy   = rmbb_pkg::Sum2W'(pyy);
        addend.mn_x   = px;
        addend.mn_y   = py;
        addend.mx_x   = px;
        addend.mx_y   = py;
      end
      rmbb_pkg::FUNC_MERGE: begin
        // Child values beyond the limits would saturate anyway, so they are
        // capped here to keep the accumulate adders narrow.
        addend.d_area = (child_area > rmbb_pkg::AREA_LIMIT) ?
                        rmbb_pkg::AREA_LIMIT : child_area;
        addend.d_x    = (child_sum_x > Lim1) ? Lim1 : child_sum_x;
        addend.d_y    = (child_sum_y > Lim1) ? Lim1 : child_sum_y;
        addend.d_xx   = (child_sum_xx > Lim2) ? Lim2 : child_sum_xx;
        addend.d_xy   = (child_sum_xy > Lim2) ? Lim2 : child_sum_xy;
        addend.d_yy   = (child_sum_yy > Lim2) ? Lim2 : child_sum_yy;
        addend.mn_x   = box_clamp(x_or_min_x);
        addend.mn_y   = box_clamp(y_or_min_y);
        addend.mx_x   = box_clamp(child_max_x);
        addend.mx_y   = box_clamp(child_max_y);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[tb/region_moment_bbox_accumulator_test.sv]
`default_nettype none

module region_moment_bbox_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmbb_pkg::*;

  // The selector value that names no operation; the block must leave the
  // region alone and still answer with the current statistics.
  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;

  // Saturation points of the region statistics, derived from the largest
  // pixel coordinate the instance is built for.
  localparam logic [63:0] COORD_CAP = 64'(MAX_COORD_DEF);
  localparam logic [63:0] COUNT_CAP = 64'(AREA_LIMIT);
  localparam logic [63:0] SUM1_RAW  = COUNT_CAP * COORD_CAP;
  localparam logic [63:0] SUM1_CAP  = (SUM1_RAW > MASK36) ? MASK36 : SUM1_RAW;
  localparam logic [63:0] SUM2_RAW  = COUNT_CAP * COORD_CAP * COORD_CAP;
  localparam logic [63:0] SUM2_CAP  = (SUM2_RAW > MASK48) ? MASK48 : SUM2_RAW;
  localparam logic [63:0] ALL_ONES  = '1;
  localparam int unsigned COORD_TOP = (1 << CoordW) - 1;

  // Lengths of the individual phases of the run.
  localparam int HOLD_CYCLES  = 40;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_WORDS = 1200;
  localparam int QUIET_WORDS  = 120;

  // One input word, laid out like the input ports.
  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [CoordW-1:0] x_or_min_x;
    logic [CoordW-1:0] y_or_min_y;
    logic [CoordW-1:0] child_max_x;
    logic [CoordW-1:0] child_max_y;
    logic [AreaW-1:0]  child_area;
    logic [Sum1W-1:0]  child_sum_x;
    logic [Sum1W-1:0]  child_sum_y;
    logic [Sum2W-1:0]  child_sum_xx;
    logic [Sum2W-1:0]  child_sum_xy;
    logic [Sum2W-1:0]  child_sum_yy;
  } region_word_t;

  // Statistics of the region. Saturated values always fit the output widths,
  // so the same record serves as the tracked state and as one result word.
  typedef struct packed {
    logic [AreaW-1:0]  area;
    logic [Sum1W-1:0]  sum_x;
    logic [Sum1W-1:0]  sum_y;
    logic [Sum2W-1:0]  sum_xx;
    logic [Sum2W-1:0]  sum_xy;
    logic [Sum2W-1:0]  sum_yy;
    logic [CoordW-1:0] min_x;
    logic [CoordW-1:0] min_y;
    logic [CoordW-1:0] max_x;
    logic [CoordW-1:0] max_y;
  } region_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FuncW-1:0]  in_func = '0;
  logic [CoordW-1:0] in_x_or_min_x = '0;
  logic [CoordW-1:0] in_y_or_min_y = '0;
  logic [CoordW-1:0] in_child_max_x = '0;
  logic [CoordW-1:0] in_child_max_y = '0;
  logic [AreaW-1:0]  in_child_area = '0;
  logic [Sum1W-1:0]  in_child_sum_x = '0;
  logic [Sum1W-1:0]  in_child_sum_y = '0;
  logic [Sum2W-1:0]  in_child_sum_xx = '0;
  logic [Sum2W-1:0]  in_child_sum_xy = '0;
  logic [Sum2W-1:0]  in_child_sum_yy = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [AreaW-1:0]  out_area;
  logic [Sum1W-1:0]  out_sum_x;
  logic [Sum1W-1:0]  out_sum_y;
  logic [Sum2W-1:0]  out_sum_xx;
  logic [Sum2W-1:0]  out_sum_xy;
  logic [Sum2W-1:0]  out_sum_yy;
  logic [CoordW-1:0] out_min_x;
  logic [CoordW-1:0] out_min_y;
  logic [CoordW-1:0] out_max_x;
  logic [CoordW-1:0] out_max_y;

  // Tracked region state and the statistics still owed by the block, oldest
  // first. Each accepted word owes exactly one result word.
  region_stats_t region_model;
  region_stats_t pending_stats[$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  stall_left = 0;
  // Random bursts of idle cycles on both channels are enabled by this flag.
  logic idle_on = 1'b1;
  // A test raises this to make the receiver hold off for a long stretch.
  logic hold_request = 1'b0;

  region_moment_bbox_accumulator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_x_or_min_x  (in_x_or_min_x),
    .in_y_or_min_y  (in_y_or_min_y),
    .in_child_max_x (in_child_max_x),
    .in_child_max_y (in_child_max_y),
    .in_child_area  (in_child_area),
    .in_child_sum_x (in_child_sum_x),
    .in_child_sum_y (in_child_sum_y),
    .in_child_sum_xx(in_child_sum_xx),
    .in_child_sum_xy(in_child_sum_xy),
    .in_child_sum_yy(in_child_sum_yy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_area       (out_area),
    .out_sum_x      (out_sum_x),
    .out_sum_y      (out_sum_y),
    .out_sum_xx     (out_sum_xx),
    .out_sum_xy     (out_sum_xy),
    .out_sum_yy     (out_sum_yy),
    .out_min_x      (out_min_x),
    .out_min_y      (out_min_y),
    .out_max_x      (out_max_x),
    .out_max_y      (out_max_y)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Region statistics predictor.
  // ---------------------------------------------------------------------

  function automatic logic [63:0] clip(logic [63:0] v, logic [63:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  // Both terms are clipped first, so the 64-bit sum never wraps.
  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    return clip(clip(a, lim) + clip(b, lim), lim);
  endfunction

  function automatic region_stats_t empty_region();
    region_stats_t s;
    s = '0;
    s.min_x = BOX_EMPTY;
    s.min_y = BOX_EMPTY;
    return s;
  endfunction

  // Applies one word to the region and returns the statistics afterward.
  function automatic region_stats_t apply_word(region_stats_t s, region_word_t w);
    logic [63:0] x, y, lo_x, lo_y, hi_x, hi_y;
    logic [63:0] d_area, d_x, d_y, d_xx, d_xy, d_yy;
    if (w.func == FUNC_ADD) begin
      // A pixel beyond the largest coordinate counts as sitting on it.
      x = clip(64'(w.x_or_min_x), COORD_CAP);
      y = clip(64'(w.y_or_min_y), COORD_CAP);
      d_area = 64'd1;
      d_x = x;
      d_y = y;
      d_xx = x * x;
      d_xy = x * y;
      d_yy = y * y;
      lo_x = x;
      hi_x = x;
      lo_y = y;
      hi_y = y;
    end else begin
      // A child box edge beyond the empty sentinel is pulled back to it.
      lo_x = clip(64'(w.x_or_min_x), 64'(BOX_EMPTY));
      lo_y = clip(64'(w.y_or_min_y), 64'(BOX_EMPTY));
      hi_x = clip(64'(w.child_max_x), 64'(BOX_EMPTY));
      hi_y = clip(64'(w.child_max_y), 64'(BOX_EMPTY));
      d_area = 64'(w.child_area);
      d_x = 64'(w.child_sum_x);
      d_y = 64'(w.child_sum_y);
      d_xx = 64'(w.child_sum_xx);
      d_xy = 64'(w.child_sum_xy);
      d_yy = 64'(w.child_sum_yy);
    end
    if (w.func == FUNC_ADD || w.func == FUNC_MERGE) begin
      s.area   = AreaW'(sat_sum(64'(s.area), d_area, COUNT_CAP));
      s.sum_x  = Sum1W'(sat_sum(64'(s.sum_x), d_x, SUM1_CAP));
      s.sum_y  = Sum1W'(sat_sum(64'(s.sum_y), d_y, SUM1_CAP));
      s.sum_xx = Sum2W'(sat_sum(64'(s.sum_xx), d_xx, SUM2_CAP));
      s.sum_xy = Sum2W'(sat_sum(64'(s.sum_xy), d_xy, SUM2_CAP));
      s.sum_yy = Sum2W'(sat_sum(64'(s.sum_yy), d_yy, SUM2_CAP));
      if (lo_x < 64'(s.min_x)) s.min_x = CoordW'(lo_x);
      if (lo_y < 64'(s.min_y)) s.min_y = CoordW'(lo_y);
      if (hi_x > 64'(s.max_x)) s.max_x = CoordW'(hi_x);
      if (hi_y > 64'(s.max_y)) s.max_y = CoordW'(hi_y);
    end else if (w.func == FUNC_CLEAR) begin
      s = empty_region();
    end
    // The unused selector falls through and leaves the region unchanged.
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Word builders.
  // ---------------------------------------------------------------------

  // Every field random over its full width, so every bit sees both values.
  function automatic region_word_t noise_word();
    region_word_t w;
    w.func         = FuncW'($urandom);
    w.x_or_min_x   = CoordW'($urandom);
    w.y_or_min_y   = CoordW'($urandom);
    w.child_max_x  = CoordW'($urandom);
    w.child_max_y  = CoordW'($urandom);
    w.child_area   = AreaW'($urandom);
    w.child_sum_x  = Sum1W'({$urandom, $urandom});
    w.child_sum_y  = Sum1W'({$urandom, $urandom});
    w.child_sum_xx = Sum2W'({$urandom, $urandom});
    w.child_sum_xy = Sum2W'({$urandom, $urandom});
    w.child_sum_yy = Sum2W'({$urandom, $urandom});
    return w;
  endfunction

  // Fields that an operation does not name are left random: the block must
  // ignore them.
  function automatic region_word_t op_word(logic [FuncW-1:0] f);
    region_word_t w;
    w = noise_word();
    w.func = f;
    return w;
  endfunction

  function automatic region_word_t add_word(int unsigned x, int unsigned y);
    region_word_t w;
    w = op_word(FUNC_ADD);
    w.x_or_min_x = CoordW'(x);
    w.y_or_min_y = CoordW'(y);
    return w;
  endfunction

  function automatic region_word_t merge_word(
    int unsigned lo_x, int unsigned lo_y, int unsigned hi_x, int unsigned hi_y,
    logic [63:0] n, logic [63:0] sx, logic [63:0] sy,
    logic [63:0] sxx, logic [63:0] sxy, logic [63:0] syy
  );
    region_word_t w;
    w.func         = FUNC_MERGE;
    w.x_or_min_x   = CoordW'(lo_x);
    w.y_or_min_y   = CoordW'(lo_y);
    w.child_max_x  = CoordW'(hi_x);
    w.child_max_y  = CoordW'(hi_y);
    w.child_area   = AreaW'(n);
    w.child_sum_x  = Sum1W'(sx);
    w.child_sum_y  = Sum1W'(sy);
    w.child_sum_xx = Sum2W'(sxx);
    w.child_sum_xy = Sum2W'(sxy);
    w.child_sum_yy = Sum2W'(syy);
    return w;
  endfunction

  // Mostly in-range coordinates, with the edges and the clamped range mixed in.
  function automatic int unsigned rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom_range(MAX_COORD_DEF + 1, COORD_TOP);
    if (pick == 1) return ($urandom_range(0, 1) != 0) ? MAX_COORD_DEF : 0;
    return $urandom_range(0, MAX_COORD_DEF);
  endfunction

  // A child region: either statistics that a real region of uniform
  // position could have, values close to the saturation points, or noise.
  function automatic region_word_t rand_child_word(bit near_limit);
    int unsigned n, cx, cy;
    region_word_t w;
    if (near_limit) begin
      return merge_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        COUNT_CAP - 1000 + $urandom_range(0, 2000),
                        SUM1_CAP - 100000 + $urandom_range(0, 101000),
                        SUM1_CAP - 100000 + $urandom_range(0, 101000),
                        SUM2_CAP - 10000000 + $urandom_range(0, 10001000),
                        SUM2_CAP - 10000000 + $urandom_range(0, 10001000),
                        SUM2_CAP - 10000000 + $urandom_range(0, 10001000));
    end
    if ($urandom_range(0, 4) == 0) begin
      w = noise_word();
      w.func = FUNC_MERGE;
      return w;
    end
    n = $urandom_range(1, 4000);
    cx = $urandom_range(0, MAX_COORD_DEF);
    cy = $urandom_range(0, MAX_COORD_DEF);
    return merge_word($urandom_range(0, cx), $urandom_range(0, cy),
                      $urandom_range(cx, MAX_COORD_DEF), $urandom_range(cy, MAX_COORD_DEF),
                      64'(n), 64'(n) * cx, 64'(n) * cy,
                      64'(n) * cx * cx, 64'(n) * cx * cy, 64'(n) * cy * cy);
  endfunction

  // ---------------------------------------------------------------------
  // Input channel.
  // ---------------------------------------------------------------------

  // Offers one word, holds it until it is taken, and records what the region
  // should look like once the block has applied it. Valid is left high on
  // return, so back-to-back words keep it high without a dip.
  task automatic send_word(region_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= w.func;
    in_x_or_min_x   <= w.x_or_min_x;
    in_y_or_min_y   <= w.y_or_min_y;
    in_child_max_x  <= w.child_max_x;
    in_child_max_y  <= w.child_max_y;
    in_child_area   <= w.child_area;
    in_child_sum_x  <= w.child_sum_x;
    in_child_sum_y  <= w.child_sum_y;
    in_child_sum_xx <= w.child_sum_xx;
    in_child_sum_xy <= w.child_sum_xy;
    in_child_sum_yy <= w.child_sum_yy;
    do @(posedge clk); while (in_stall);
    region_model = apply_word(region_model, w);
    pending_stats = {pending_stats, region_model};
    words_sent++;
  endtask

  // Stops offering words and waits until every owed result has come back,
  // then lets the pipeline settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A run of pixels of one region, with the odd child merge in between.
  task automatic region_words(int n);
    repeat (n) begin
      if ($urandom_range(0, 6) == 0) send_word(rand_child_word(1'b0));
      else send_word(add_word(rand_coord(), rand_coord()));
    end
  endtask

  // ---------------------------------------------------------------------
  // Result channel.
  // ---------------------------------------------------------------------

  // The receiver stalls in short random bursts, or for one long stretch when
  // a test asks for it. The count lives here so the stretch is measured in
  // cycles no matter what the sender is doing.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 3);
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Every result word taken is compared with the oldest owed statistics.
  always @(posedge clk) begin : check_results
    region_stats_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: result word arrived with nothing owed", $time);
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        check_field("area", 64'(want.area), 64'(out_area));
        check_field("sum_x", 64'(want.sum_x), 64'(out_sum_x));
        check_field("sum_y", 64'(want.sum_y), 64'(out_sum_y));
        check_field("sum_xx", 64'(want.sum_xx), 64'(out_sum_xx));
        check_field("sum_xy", 64'(want.sum_xy), 64'(out_sum_xy));
        check_field("sum_yy", 64'(want.sum_yy), 64'(out_sum_yy));
        check_field("min_x", 64'(want.min_x), 64'(out_min_x));
        check_field("min_y", 64'(want.min_y), 64'(out_min_y));
        check_field("max_x", 64'(want.max_x), 64'(out_max_x));
        check_field("max_y", 64'(want.max_y), 64'(out_max_y));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Field extremes, all four selector values and each special case: pixel
  // clamping, child box clamping, out-of-range child counts and sums, exact
  // saturation of the count and the sums, and the empty child.
  task automatic test_directed_cases();
    send_word(add_word(0, 0));
    send_word(add_word(MAX_COORD_DEF, MAX_COORD_DEF));
    send_word(add_word(MAX_COORD_DEF + 1, 3));
    send_word(add_word(COORD_TOP, COORD_TOP));
    send_word(op_word(FUNC_UNUSED));
    // An empty child must leave the box and the sums as they are.
    send_word(merge_word(BOX_EMPTY, BOX_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(merge_word(0, 0, COORD_TOP, COORD_TOP, 5, 10, 20, 30, 40, 50));
    send_word(op_word(FUNC_CLEAR));
    // A child whose box minimum lies past the sentinel gets pulled back to it.
    send_word(merge_word(COORD_TOP, COORD_TOP, BOX_EMPTY, BOX_EMPTY, 1, 2, 3, 4, 5, 6));
    send_word(op_word(FUNC_CLEAR));
    // All ones in every child field: the count and every sum saturate at once.
    send_word(merge_word(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, ALL_ONES,
                         ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    send_word(add_word(0, 0));
    send_word(op_word(FUNC_CLEAR));
    // Just under the limits, then two pixels run some of them over.
    send_word(merge_word(100, 200, 300, 400, COUNT_CAP - 1, SUM1_CAP - 2, SUM1_CAP - 5000,
                         SUM2_CAP - 3, SUM2_CAP - 1, SUM2_CAP - 100000000));
    send_word(add_word(MAX_COORD_DEF, MAX_COORD_DEF));
    send_word(add_word(1, 1));
    send_word(op_word(FUNC_CLEAR));
    // Exactly at the limits, then an all-zero child.
    send_word(merge_word(BOX_EMPTY, BOX_EMPTY, 0, 0, COUNT_CAP, SUM1_CAP, SUM1_CAP,
                         SUM2_CAP, SUM2_CAP, SUM2_CAP));
    send_word(merge_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_CLEAR));
    send_word(add_word(10, 20));
    send_word(add_word(5, 30));
    send_word(op_word(FUNC_UNUSED));
    send_word(op_word(FUNC_CLEAR));
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the block fills up and must stall its input without losing a word.
  task automatic test_output_hold();
    hold_request = 1'b1;
    send_word(op_word(FUNC_CLEAR));
    region_words(14);
  endtask

  // The sender goes quiet until every owed result is back, then resumes on
  // the same region.
  task automatic test_sender_pause();
    region_words(6);
    wait_for_results();
    region_words(6);
  endtask

  // Mostly whole regions: a clear followed by pixels and child merges. The
  // rest is noise, regions that carry on without a clear, and regions that
  // start from a child near saturation.
  task automatic test_random_regions();
    int stop_at;
    int unsigned pick;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_word(op_word(FUNC_CLEAR));
        region_words($urandom_range(1, 24));
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 4)) send_word(noise_word());
      end else if (pick == 8) begin
        region_words($urandom_range(1, 8));
      end else begin
        send_word(rand_child_word(1'b1));
        region_words($urandom_range(1, 6));
      end
    end
  endtask

  // Back-to-back words with both sides always ready.
  task automatic test_quiet_stream();
    idle_on = 1'b0;
    send_word(op_word(FUNC_CLEAR));
    region_words(QUIET_WORDS);
  endtask

  initial begin
    region_model = empty_region();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_output_hold();
    test_sender_pause();
    test_random_regions();
    test_quiet_stream();
    wait_for_results();
    if (mismatches == 0) begin
      $display("region_moment_bbox_accumulator regression: pass");
    end else begin
      $display("region_moment_bbox_accumulator regression: fail");
    end
    $finish;
  end

  // Far beyond the slowest correct run, which stays well under 100 us.
  initial begin
    #2_000_000;
    $display("region_moment_bbox_accumulator regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
